FILE: rtl/core/sfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants for the sprite frame sequencer and its divider.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // Largest frame count a clip may use.
    localparam int MAX_FRAMES = 1024;
    // Indices a 10-bit frame index can hold.
    localparam int INDEX_LIMIT = 1024;
    localparam int CNT_LIMIT = (MAX_FRAMES < INDEX_LIMIT) ? MAX_FRAMES : INDEX_LIMIT;

    localparam int TICK_W = 16;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int PIXEL_W = 12;
    localparam int SRCX_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // The divider takes an 18-bit dividend, one quotient bit per cycle.
    localparam int DIVIDEND_W = 18;
    localparam int DIVISOR_W = 16;
    localparam int DIV_STEPS = DIVIDEND_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_TICKS = 3'd0,
        REG_FRAME_TOTAL = 3'd1,
        REG_LOOP_MODE   = 3'd2,
        REG_ORIGIN_X    = 3'd3,
        REG_ORIGIN_Y    = 3'd4,
        REG_CELL_WIDTH  = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        CMD_ADVANCE = 1'b0,
        CMD_RESTART = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TIME,
        ST_DIV_WRAP,
        ST_MULT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
        logic [DIVISOR_W-1:0]  rem;
    } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/sfs_div_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_div_unit
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module sfs_div_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sfs_pkg::div_req_t req,
    output sfs_pkg::div_rsp_t      rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [sfs_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [sfs_pkg::DIVIDEND_W-1:0]     quo_reg, quo_next;
    logic [sfs_pkg::DIVISOR_W-1:0]      rem_reg, rem_next;
    logic [sfs_pkg::DIVISOR_W-1:0]      dvs_reg, dvs_next;
    logic [sfs_pkg::DIVISOR_W:0]        partial;
    logic [sfs_pkg::DIVISOR_W:0]        diff;
    logic                               ge;

    // The partial remainder takes the next dividend bit from the top of the
    // quotient shift register; quotient bits enter at the bottom.
    always_comb begin
        partial = {rem_reg, quo_reg[sfs_pkg::DIVIDEND_W-1]};
        diff    = partial - {1'b0, dvs_reg};
        ge      = partial >= {1'b0, dvs_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[sfs_pkg::DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[sfs_pkg::DIVISOR_W-1:0] : partial[sfs_pkg::DIVISOR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

FILE: rtl/core/sprite_frame_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// A restart, an ignored command or an advance without a frame step passes from the
// input transaction through ST_MULT and ST_OUT to the registered result; an advance
// with a frame step passes ST_DIV_TIME first, and ST_DIV_WRAP too when wrapping (one or
// two divider passes). The next command is taken in the same cycle as the result is
// offered; no new command is taken before then. Reset (aresetn, synchronous, active low)
// restores the state, tick count, frame index and clip registers and empties the output.
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite-strip animation sequencer: advances a frame index by elapsed ticks or
// restarts it, wraps or clamps it, and reports the source rectangle origin of the frame.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port, no read-back.
    input  wire logic                              cfg_wr_en,
    input  wire logic [sfs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Command stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sfs_pkg::IN_DATA_W-1:0]     s_tdata,  // [15:0] elapsed
    input  wire logic                              s_tuser,  // [0] cmd
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [9:0] frame_index, [25:10] src_x, [37:26] src_y, [39:38] zero
    output logic [sfs_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tuser   // [0] changed
);

    // Frame counts are limited by the clip maximum and by the index range.
    localparam int CNT_LIMIT = (MAX_FRAMES < sfs_pkg::INDEX_LIMIT)
                               ? MAX_FRAMES : sfs_pkg::INDEX_LIMIT;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are to arrive only while the block is idle;
    // the block does not enforce this, and the datapath reads them directly.
    // ------------------------------------------------------------------
    logic [sfs_pkg::TICK_W-1:0]   frame_ticks_reg;
    logic [sfs_pkg::COUNT_W-1:0]  frame_total_reg;
    logic                         loop_mode_reg;
    logic [sfs_pkg::PIXEL_W-1:0]  origin_x_reg;
    logic [sfs_pkg::PIXEL_W-1:0]  origin_y_reg;
    logic [sfs_pkg::PIXEL_W-1:0]  cell_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_ticks_reg <= sfs_pkg::TICK_W'(1);
            frame_total_reg <= '0;
            loop_mode_reg   <= 1'b0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cell_width_reg  <= sfs_pkg::PIXEL_W'(1);
        end else if (cfg_wr_en) begin
            case (sfs_pkg::cfg_reg_t'(cfg_addr))
                sfs_pkg::REG_FRAME_TICKS: frame_ticks_reg <= cfg_wdata;
                sfs_pkg::REG_FRAME_TOTAL: frame_total_reg <= cfg_wdata[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::REG_LOOP_MODE:   loop_mode_reg   <= cfg_wdata[0];
                sfs_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg_wdata[sfs_pkg::PIXEL_W-1:0];
                sfs_pkg::REG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata[sfs_pkg::PIXEL_W-1:0];
                sfs_pkg::REG_CELL_WIDTH:  cell_width_reg  <= cfg_wdata[sfs_pkg::PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame count: saturated to the clip maximum and the index range.
    // A zero duration behaves as a one-tick frame.
    logic [sfs_pkg::COUNT_W-1:0] count_eff;
    logic [sfs_pkg::TICK_W-1:0]  dur;

    always_comb begin
        count_eff = (frame_total_reg > sfs_pkg::COUNT_W'(CNT_LIMIT))
                    ? sfs_pkg::COUNT_W'(CNT_LIMIT) : frame_total_reg;
        dur = (frame_ticks_reg == '0) ? sfs_pkg::TICK_W'(1) : frame_ticks_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer state and working registers.
    // ------------------------------------------------------------------
    sfs_pkg::state_t                 state_reg, state_next;
    logic [sfs_pkg::TICK_W-1:0]      tick_accum_reg, tick_accum_next;
    logic [sfs_pkg::INDEX_W-1:0]     cur_frame_reg, cur_frame_next;
    logic                            changed_reg, changed_next;
    logic [sfs_pkg::SRCX_W-1:0]      src_x_reg, src_x_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [sfs_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                            m_tuser_reg, m_tuser_next;

    sfs_pkg::div_req_t div_req;
    sfs_pkg::div_rsp_t div_rsp;

    logic                              in_fire;
    logic                              out_free;
    logic [sfs_pkg::TICK_W:0]          sum;
    logic                              sum_reaches;
    logic [sfs_pkg::DIVIDEND_W-1:0]    next_frame;
    logic                              next_in_range;
    logic [21:0]                       cell_prod;

    assign s_tready = (state_reg == sfs_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        sum         = {1'b0, tick_accum_reg} + {1'b0, s_tdata[sfs_pkg::TICK_W-1:0]};
        sum_reaches = sum >= {1'b0, dur};
        // The quotient of the tick division is at most 17 bits wide.
        next_frame  = {{(sfs_pkg::DIVIDEND_W - sfs_pkg::INDEX_W){1'b0}}, cur_frame_reg}
                      + div_rsp.quot;
        next_in_range = next_frame <
                        {{(sfs_pkg::DIVIDEND_W - sfs_pkg::COUNT_W){1'b0}}, count_eff};
        cell_prod   = 22'(cell_width_reg) * 22'(cur_frame_reg);
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (count_eff != '0 && s_tuser == sfs_pkg::CMD_ADVANCE && sum_reaches) begin
                        state_next = sfs_pkg::ST_DIV_TIME;
                    end else begin
                        state_next = sfs_pkg::ST_MULT;
                    end
                end
            end
            sfs_pkg::ST_DIV_TIME: begin
                if (div_rsp.done) begin
                    state_next = loop_mode_reg ? sfs_pkg::ST_DIV_WRAP : sfs_pkg::ST_MULT;
                end
            end
            sfs_pkg::ST_DIV_WRAP: begin
                if (div_rsp.done) begin
                    state_next = sfs_pkg::ST_MULT;
                end
            end
            sfs_pkg::ST_MULT: begin
                state_next = sfs_pkg::ST_OUT;
            end
            sfs_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = sfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        tick_accum_next = tick_accum_reg;
        cur_frame_next  = cur_frame_reg;
        changed_next    = changed_reg;
        src_x_next      = src_x_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        div_req.start    = 1'b0;
        div_req.dividend = {{(sfs_pkg::DIVIDEND_W - sfs_pkg::TICK_W - 1){1'b0}}, sum};
        div_req.divisor  = dur;

        case (state_reg)
            sfs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    changed_next = 1'b0;
                    if (count_eff != '0) begin
                        if (s_tuser == sfs_pkg::CMD_RESTART) begin
                            cur_frame_next  = '0;
                            tick_accum_next = '0;
                            changed_next    = 1'b1;
                        end else if (sum_reaches) begin
                            // Split the accumulated ticks into whole frames and
                            // a leftover remainder.
                            div_req.start = 1'b1;
                        end else begin
                            tick_accum_next = sum[sfs_pkg::TICK_W-1:0];
                        end
                    end
                end
            end
            sfs_pkg::ST_DIV_TIME: begin
                div_req.dividend = next_frame;
                div_req.divisor  = {{(sfs_pkg::DIVISOR_W - sfs_pkg::COUNT_W){1'b0}}, count_eff};
                if (div_rsp.done) begin
                    tick_accum_next = div_rsp.rem;
                    changed_next    = 1'b1;
                    if (loop_mode_reg) begin
                        // Wrap the index by a second pass through the divider.
                        div_req.start = 1'b1;
                    end else if (next_in_range) begin
                        cur_frame_next = next_frame[sfs_pkg::INDEX_W-1:0];
                    end else begin
                        cur_frame_next = sfs_pkg::INDEX_W'(count_eff - 1'b1);
                    end
                end
            end
            sfs_pkg::ST_DIV_WRAP: begin
                if (div_rsp.done) begin
                    cur_frame_next = div_rsp.rem[sfs_pkg::INDEX_W-1:0];
                end
            end
            sfs_pkg::ST_MULT: begin
                src_x_next = cell_prod[sfs_pkg::SRCX_W-1:0]
                             + {{(sfs_pkg::SRCX_W - sfs_pkg::PIXEL_W){1'b0}}, origin_x_reg};
            end
            sfs_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, origin_y_reg, src_x_reg, cur_frame_reg};
                    m_tuser_next  = changed_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sfs_pkg::ST_IDLE;
            tick_accum_reg <= '0;
            cur_frame_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_accum_reg <= tick_accum_next;
            cur_frame_reg  <= cur_frame_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        changed_reg <= changed_next;
        src_x_reg   <= src_x_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    sfs_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite frame sequencer. Commands go in on the
// slave stream and are tracked by a behavioral animation model kept in this
// file. Every result on the master stream is checked against the oldest
// predicted frame. Directed clip setups come first, then randomized clips;
// random idle bursts on both streams run until the final randomized phases.
// ----------------------------------------------------------------------------
module tb_top;
    import sfs_pkg::*;

    // Generous watchdog.
    localparam int CYCLE_LIMIT = 500000;
    // Slack left after the final drain.
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    // One result of the block, unpacked from m_tdata and m_tuser.
    typedef struct packed {
        logic [INDEX_W-1:0] frame_index;
        logic [SRCX_W-1:0]  src_x;
        logic [PIXEL_W-1:0] src_y;
        logic               changed;
    } frame_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_reg_t              cfg_addr = REG_FRAME_TICKS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // [15:0] elapsed
    logic                  s_tuser = 1'b0; // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // [9:0] index, [25:10] x, [37:26] y
    logic                  m_tuser;        // [0] changed

    // Copy of the clip registers as the block should hold them.
    logic [TICK_W-1:0]  clip_ticks;
    logic [COUNT_W-1:0] clip_total;
    logic               clip_loop;
    logic [PIXEL_W-1:0] clip_x;
    logic [PIXEL_W-1:0] clip_y;
    logic [PIXEL_W-1:0] clip_cell_w;

    // Animation state as the block should hold it.
    logic [TICK_W-1:0]  anim_ticks;
    logic [INDEX_W-1:0] anim_frame;

    frame_result_t expected_frames[$];
    int  error_count = 0;
    int  report_count = 0;
    int  cycle_count = 0;
    int  sink_stall = 0;
    // Random idle bursts on both streams; cleared for the last part of the run.
    bit  idle_enable = 1'b0;

    sprite_frame_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_frames.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result-side backpressure in random stall bursts.
    always @(posedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            sink_stall <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Animation model. Applies one command to the tracked state and returns the
    // result the block must produce for it.
    function automatic frame_result_t advance_animation(input cmd_t op,
                                                        input logic [TICK_W-1:0] elapsed);
        int unsigned   count;
        int unsigned   dur;
        int unsigned   total_ticks;
        int unsigned   next_frame;
        int unsigned   xpos;
        frame_result_t r;
        // Frame counts beyond the clip maximum or what the index can address are saturated.
        count = 32'(clip_total);
        if (count > MAX_FRAMES) count = MAX_FRAMES;
        if (count > INDEX_LIMIT) count = INDEX_LIMIT;
        r.changed = 1'b0;
        // With no clip loaded the command is dropped and the held frame reported.
        if (count != 0) begin
            if (op == CMD_RESTART) begin
                anim_frame = '0;
                anim_ticks = '0;
                r.changed = 1'b1;
            end else begin
                // A zero frame duration counts as one tick.
                dur = (clip_ticks == '0) ? 1 : 32'(clip_ticks);
                total_ticks = 32'(anim_ticks) + 32'(elapsed);
                if (total_ticks >= dur) begin
                    next_frame = 32'(anim_frame) + total_ticks / dur;
                    anim_ticks = TICK_W'(total_ticks % dur);
                    if (clip_loop)
                        anim_frame = INDEX_W'(next_frame % count);
                    else
                        anim_frame = INDEX_W'((next_frame < count) ? next_frame : count - 1);
                    // Reaching the duration marks the rectangle as set even when
                    // a clamped index does not move.
                    r.changed = 1'b1;
                end else begin
                    anim_ticks = TICK_W'(total_ticks);
                end
            end
        end
        xpos = 32'(clip_x) + 32'(clip_cell_w) * 32'(anim_frame);
        r.frame_index = anim_frame;
        r.src_x = 16'(xpos);
        r.src_y = clip_y;
        return r;
    endfunction

    // Result checker: every transaction on the master side is compared with
    // the oldest prediction still waiting.
    always @(posedge aclk) begin
        frame_result_t seen;
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.frame_index = m_tdata[9:0];
            seen.src_x = m_tdata[25:10];
            seen.src_y = m_tdata[37:26];
            seen.changed = m_tuser;
            if (expected_frames.size() == 0) begin
                error_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("%0t: unexpected result index=%0d x=%0d y=%0d changed=%0b",
                             $realtime, seen.frame_index, seen.src_x, seen.src_y,
                             seen.changed);
                end
            end else begin
                want = expected_frames.pop_front();
                if (seen.frame_index !== want.frame_index || seen.src_x !== want.src_x
                        || seen.src_y !== want.src_y || seen.changed !== want.changed) begin
                    error_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("%0t: mismatch expected index=%0d x=%0d y=%0d changed=%0b",
                                 $realtime, want.frame_index, want.src_x, want.src_y,
                                 want.changed);
                        $display("%0t:            actual index=%0d x=%0d y=%0d changed=%0b",
                                 $realtime, seen.frame_index, seen.src_x, seen.src_y,
                                 seen.changed);
                    end
                end
            end
        end
    end

    // Sends one command. The valid stays high after the transaction so that a
    // following command can go out back to back; drain_results lowers it.
    task automatic send_command(input cmd_t op, input logic [TICK_W-1:0] elapsed);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= elapsed;
        do @(posedge aclk); while (!s_tready);
        expected_frames.push_back(advance_animation(op, elapsed));
    endtask

    task automatic advance_by(input int unsigned elapsed);
        send_command(CMD_ADVANCE, elapsed[TICK_W-1:0]);
    endtask

    // Stops the command stream and waits until the block has returned every
    // outstanding result, so that it is idle afterwards.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= index;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Loads a whole clip setup while the block is idle. The animation state is
    // left alone, as in the block.
    task automatic load_clip(input logic [TICK_W-1:0] ticks, input logic [COUNT_W-1:0] total,
                             input logic loop_on, input logic [PIXEL_W-1:0] ox,
                             input logic [PIXEL_W-1:0] oy, input logic [PIXEL_W-1:0] cw);
        drain_results();
        write_reg(REG_FRAME_TICKS, ticks);
        write_reg(REG_FRAME_TOTAL, CFG_DATA_W'(total));
        write_reg(REG_LOOP_MODE, CFG_DATA_W'(loop_on));
        write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
        write_reg(REG_CELL_WIDTH, CFG_DATA_W'(cw));
        cfg_wr_en <= 1'b0;
        clip_ticks = ticks;
        clip_total = total;
        clip_loop = loop_on;
        clip_x = ox;
        clip_y = oy;
        clip_cell_w = cw;
    endtask

    // Defaults after reset hold no clip, so every command is dropped.
    task automatic test_no_clip();
        advance_by(16'hFFFF);
        send_command(CMD_RESTART, 16'h0000);
    endtask

    // Holding mode: ticks below the duration, an exact step, a huge jump that
    // clamps, a step at the last frame that keeps the index, a restart, then a zero advance.
    task automatic test_clamp_mode();
        load_clip(16'd3, 11'd5, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF);
        advance_by(2);
        advance_by(1);
        advance_by(16'hFFFF);
        advance_by(3);
        send_command(CMD_RESTART, 16'hFFFF);
        advance_by(0);
    endtask

    // Looping mode with a zero duration (one tick) and an oversized frame count
    // that saturates to 1024. The x origin overflows 16 bits at high indices.
    task automatic test_wrap_mode();
        load_clip(16'd0, 11'd2047, 1'b1, 12'hFFF, 12'h000, 12'hFFF);
        advance_by(1023);
        advance_by(1);
        advance_by(16'hFFFF);
        send_command(CMD_RESTART, 16'h0000);
    endtask

    // Longest duration: the tick sum exceeds 16 bits. Zero cell width keeps x
    // at the origin.
    task automatic test_long_frames();
        load_clip(16'hFFFF, 11'd1024, 1'b0, 12'h000, 12'h000, 12'h000);
        advance_by(16'hFFFE);
        advance_by(16'hFFFF);
    endtask

    // Frame count lowered under the held index: the index is reported as is
    // until the next step pulls it into range by clamping or wrapping. Finally
    // the clip is unloaded while a frame is held.
    task automatic test_count_change();
        load_clip(16'd1, 11'd1024, 1'b1, 12'd37, 12'd99, 12'd3);
        advance_by(1000);
        load_clip(16'd1, 11'd10, 1'b0, 12'd37, 12'd99, 12'd3);
        advance_by(0);
        advance_by(1);
        load_clip(16'd1, 11'd1024, 1'b1, 12'd37, 12'd99, 12'd3);
        advance_by(500);
        load_clip(16'd1, 11'd7, 1'b1, 12'd37, 12'd99, 12'd3);
        advance_by(1);
        load_clip(16'd1, 11'd0, 1'b1, 12'd5, 12'd6, 12'd7);
        advance_by(5);
    endtask

    // Randomized clips. Each phase loads a new setup and sends a stream of
    // commands whose elapsed times are mostly scaled to the frame duration, so
    // that steps, wraps and clamps all occur often.
    task automatic test_random(input int phases, input int per_phase);
        logic [TICK_W-1:0]  ticks;
        logic [COUNT_W-1:0] total;
        logic [PIXEL_W-1:0] px [3];
        int unsigned        dur;
        int unsigned        elapsed;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 5))
                0: ticks = 16'd0;
                1: ticks = 16'd1;
                2: ticks = TICK_W'($urandom_range(2, 16));
                3: ticks = TICK_W'($urandom_range(17, 1000));
                4: ticks = TICK_W'($urandom_range(1001, 65534));
                default: ticks = 16'hFFFF;
            endcase
            case ($urandom_range(0, 5))
                0: total = 11'd1;
                1: total = COUNT_W'($urandom_range(2, 16));
                2: total = COUNT_W'($urandom_range(17, 1023));
                3: total = 11'd1024;
                4: total = COUNT_W'($urandom_range(1025, 2046));
                default: total = 11'd2047;
            endcase
            foreach (px[i]) begin
                case ($urandom_range(0, 3))
                    0: px[i] = 12'h000;
                    1: px[i] = 12'hFFF;
                    default: px[i] = PIXEL_W'($urandom_range(0, 4095));
                endcase
            end
            load_clip(ticks, total, 1'($urandom_range(0, 1)), px[0], px[1], px[2]);
            dur = (ticks == '0) ? 1 : 32'(ticks);
            for (int n = 0; n < per_phase; n++) begin
                // One pause in the middle of the run until all results are back.
                if (p == phases / 2 && n == per_phase / 2)
                    drain_results();
                if ($urandom_range(0, 7) == 0) begin
                    send_command(CMD_RESTART, 16'($urandom_range(0, 65535)));
                end else begin
                    case ($urandom_range(0, 5))
                        0: elapsed = 0;
                        1: elapsed = $urandom_range(0, dur - 1);
                        2: elapsed = dur;
                        3: elapsed = dur * $urandom_range(1, 4) + $urandom_range(0, 3);
                        4: elapsed = 65535;
                        default: elapsed = $urandom_range(0, 65535);
                    endcase
                    if (elapsed > 65535) elapsed = 65535;
                    advance_by(elapsed);
                end
            end
            // The final phases run without any idle cycles.
            if (p == phases - 4)
                idle_enable = 1'b0;
        end
    endtask

    initial begin
        // Model state after reset.
        clip_ticks = 16'd1;
        clip_total = '0;
        clip_loop = 1'b0;
        clip_x = '0;
        clip_y = '0;
        clip_cell_w = 12'd1;
        anim_ticks = '0;
        anim_frame = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_enable = 1'b1;

        test_no_clip();
        test_clamp_mode();
        test_wrap_mode();
        test_long_frames();
        test_count_change();
        test_random(14, 100);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
